// ===== hdl/lgs_pkg.sv =====
package lgs_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 4096;
  localparam int BIRTH_SUM     = 3;

  localparam int WIDTH_REG_W   = 11;
  localparam int HEIGHT_REG_W  = 13;
  localparam int ROW_W         = 12;
  localparam int REG_ADDR_W    = 3;
  localparam int APB_DATA_W    = 32;
  localparam int IN_DATA_W     = 8;
  localparam int OUT_DATA_W    = 8;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(1024);
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(1024);

  localparam logic [0:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [0:0] REG_GRID_HEIGHT = 1'b1;

  typedef struct packed {
    logic next_alive;
    logic cell_changed;
  } lgs_rule_t;

endpackage

// ===== hdl/lgs_rule.sv =====
module lgs_rule (
  input  logic [8:0]        window,
  output lgs_pkg::lgs_rule_t rule
);
  import lgs_pkg::*;

  logic [3:0] sum;
  logic       centre;

  always_comb begin
    sum = 4'd0;
    for (int i = 0; i < 9; i++) begin
      sum = sum + {3'd0, window[i]};
    end
  end

  assign centre = window[4];

  always_comb begin
    rule.next_alive   = (sum == 4'(BIRTH_SUM)) || ((sum == 4'(BIRTH_SUM + 1)) && centre);
    rule.cell_changed = rule.next_alive ^ centre;
  end

endmodule

// ===== hdl/life_generation_stencil.sv =====
// the result for cell (r-1, c-1) is registered and shown in the cycle after the beat
// that carries cell (r, c); border cells give no result
// throughput: one cell per cycle unless the output stalls (one registered read port)
// reset: counters, window, change flag and output valid clear; row buffers are
// not cleared, every entry is rewritten before it reaches a result
module life_generation_stencil #(
  parameter int MAX_WIDTH = lgs_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lgs_pkg::REG_ADDR_W-1:0]    paddr,
  input  logic [lgs_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [lgs_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // bit 0 cell_alive, bits 7..1 zero
  input  logic [lgs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // bit 0 next_alive, bit 1 cell_changed, bit 2 frame_changed, bits 7..3 zero
  output logic [lgs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // last_of_frame
  output logic                              m_axis_tlast
);
  import lgs_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WCW = $clog2(MAX_WIDTH + 1);
  localparam int EW  = (WCW > WIDTH_REG_W) ? WCW : WIDTH_REG_W;

  logic [WIDTH_REG_W-1:0]  grid_width;
  logic [HEIGHT_REG_W-1:0] grid_height;
  logic [EW-1:0]           eff_w;
  logic [HEIGHT_REG_W-1:0] eff_h;
  logic                    cfg_wr;

  logic [CW-1:0]    col;
  logic [CW-1:0]    col_next;
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] row_next;
  logic             col_end;
  logic             row_end;
  logic [8:0]       window;
  logic [8:0]       window_next;
  logic             any_change;
  logic             accept;
  logic             produce;
  logic             last;

  logic [1:0]    row_mem [MAX_WIDTH];
  logic [1:0]    rd_data;
  logic [CW-1:0] rd_addr;
  logic          top;
  logic          mid;
  logic          bot;

  lgs_rule_t rule;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= WIDTH_RESET;
      grid_height <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_GRID_WIDTH:  grid_width  <= pwdata[WIDTH_REG_W-1:0];
        REG_GRID_HEIGHT: grid_height <= pwdata[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_GRID_WIDTH:  prdata = APB_DATA_W'(grid_width);
      REG_GRID_HEIGHT: prdata = APB_DATA_W'(grid_height);
      default:         prdata = '0;
    endcase
  end

  always_comb begin
    if (EW'(grid_width) < EW'(3)) begin
      eff_w = EW'(3);
    end else if (EW'(grid_width) > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(grid_width);
    end
    if (grid_height < HEIGHT_REG_W'(3)) begin
      eff_h = HEIGHT_REG_W'(3);
    end else if (grid_height > HEIGHT_REG_W'(MAX_HEIGHT)) begin
      eff_h = HEIGHT_REG_W'(MAX_HEIGHT);
    end else begin
      eff_h = grid_height;
    end
  end

  // raster position
  assign col_end  = EW'(col) == (eff_w - EW'(1));
  assign row_end  = HEIGHT_REG_W'(row) == (eff_h - HEIGHT_REG_W'(1));
  assign col_next = col_end ? '0 : col + CW'(1);
  assign row_next = col_end ? (row_end ? '0 : row + ROW_W'(1)) : row;
  assign produce  = (row >= ROW_W'(2)) && (CW'(col) >= CW'(2));
  assign last     = row_end && col_end;

  // border beats never need the output register
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready || !produce;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // row buffers, bit 0 upper row, bit 1 middle row
  assign rd_addr = (rst || cfg_wr) ? '0 : (accept ? col_next : col);

  always_ff @(posedge clk) begin
    if (accept) begin
      row_mem[col] <= {bot, mid};
    end
    rd_data <= row_mem[rd_addr];
  end

  assign top = rd_data[0];
  assign mid = rd_data[1];
  assign bot = s_axis_tdata[0];

  assign window_next = {bot, mid, top, window[8:3]};

  lgs_rule u_rule (
    .window (window_next),
    .rule   (rule)
  );

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      col        <= '0;
      row        <= '0;
      window     <= '0;
      any_change <= 1'b0;
    end else if (accept) begin
      col    <= col_next;
      row    <= row_next;
      window <= window_next;
      if (produce) begin
        any_change <= last ? 1'b0 : (any_change | rule.cell_changed);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept && produce) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && produce) begin
      m_axis_tdata <= {(OUT_DATA_W-3)'(0),
                       last && (any_change | rule.cell_changed),
                       rule.cell_changed,
                       rule.next_alive};
      m_axis_tlast <= last;
    end
  end

endmodule
